// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, left empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset
`define NSBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset
`define NSBS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define NSBS_ASSERT(lbl, clk, rst, prop, msg)
`define NSBS_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== design/nsbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest smaller both sides package
// Shared constants, command codes and inter-module types.
// ----------------------------------------------------------------------------
package nsbs_pkg;

   // default sizes
   localparam int DEFAULT_DEPTH      = 64;
   localparam int DEFAULT_VALUE_BITS = 32;

   // fixed field widths
   localparam int INDEX_BITS = 6;
   localparam int LEFT_BITS  = 7;

   // "no such element" answer, -1 in seven bits
   localparam logic [LEFT_BITS-1:0] NONE_INDEX = 7'h7F;

   // command codes
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // classification of a queued word
   typedef enum logic [1:0] {
      KIND_PUSH     = 2'd0,
      KIND_FLUSH    = 2'd1,
      KIND_OVERFLOW = 2'd2
   } nsbs_kind_type;

   typedef struct packed {
      nsbs_kind_type           kind;
      logic [INDEX_BITS-1:0]   index;
   } nsbs_tag_type;

   typedef struct packed {
      logic         valid;
      nsbs_tag_type tag;
   } nsbs_slot_type;

   // back end status seen by the top level
   typedef struct packed {
      logic [LEFT_BITS-1:0] depth;
      logic                 pending;
   } nsbs_stat_type;

endpackage

// ===== design/nsbs_front.sv =====
// ----------------------------------------------------------------------------
// Nearest smaller front end
// Accepts request words, numbers the elements of a sequence and classifies
// each word as push, flush or overflow.
// ----------------------------------------------------------------------------
module nsbs_front #(
   parameter int DEPTH = nsbs_pkg::DEFAULT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic                  q_ready,
   output nsbs_pkg::nsbs_slot_type wr_slot
);
   import nsbs_pkg::*;

   logic [LEFT_BITS-1:0] index_ff;
   logic [LEFT_BITS-1:0] index_in;
   logic                 accept;
   logic                 full_seq;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign full_seq  = (index_ff == LEFT_BITS'(DEPTH));

   // classify the word and advance the element counter
   always_comb begin
      wr_slot.valid     = req_valid;
      wr_slot.tag.index = index_ff[INDEX_BITS-1:0];
      index_in          = index_ff;
      if (req_cmd == CMD_FLUSH) begin
         wr_slot.tag.kind = KIND_FLUSH;
         if (accept) begin
            index_in = '0;
         end
      end else if (full_seq) begin
         wr_slot.tag.kind = KIND_OVERFLOW;
      end else begin
         wr_slot.tag.kind = KIND_PUSH;
         if (accept) begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else begin
         index_ff <= index_in;
      end
   end

endmodule

// ===== design/nsbs_queue.sv =====
// ----------------------------------------------------------------------------
// Nearest smaller queue
// Two-word queue between the front end and the stack engine.
// ----------------------------------------------------------------------------
module nsbs_queue #(
   parameter int VALUE_BITS = nsbs_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nsbs_pkg::nsbs_slot_type       wr_slot,
   input  logic signed [VALUE_BITS-1:0]  wr_value,
   output logic                          wr_ready,
   output nsbs_pkg::nsbs_slot_type       head_slot,
   output logic signed [VALUE_BITS-1:0]  head_value,
   input  logic                          head_pop
);
   import nsbs_pkg::*;

   nsbs_tag_type           tag_ff   [2];
   logic [VALUE_BITS-1:0]  value_ff [2];
   logic                   wr_ptr_ff;
   logic                   wr_ptr_in;
   logic                   rd_ptr_ff;
   logic                   rd_ptr_in;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic                   do_wr;
   logic                   do_rd;

   assign wr_ready        = (count_ff != 2'd2);
   assign do_wr           = wr_slot.valid && wr_ready;
   assign do_rd           = head_pop && (count_ff != 2'd0);
   assign head_slot.valid = (count_ff != 2'd0);
   assign head_slot.tag   = tag_ff[rd_ptr_ff];
   assign head_value      = $signed(value_ff[rd_ptr_ff]);

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold the words
   always_ff @(posedge clock) begin
      if (do_wr) begin
         tag_ff[wr_ptr_ff]   <= wr_slot.tag;
         value_ff[wr_ptr_ff] <= wr_value;
      end
   end

endmodule

// ===== design/nsbs_back.sv =====
// ----------------------------------------------------------------------------
// Nearest smaller stack engine
// Keeps the monotonic stack in a memory with the top cached in registers,
// pops larger entries, pushes new elements and drives the result register.
// ----------------------------------------------------------------------------
module nsbs_back #(
   parameter int DEPTH      = nsbs_pkg::DEFAULT_DEPTH,
   parameter int VALUE_BITS = nsbs_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nsbs_pkg::nsbs_slot_type       head_slot,
   input  logic signed [VALUE_BITS-1:0]  head_value,
   output logic                          head_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nsbs_pkg::INDEX_BITS-1:0]       rsp_elem_index,
   output logic signed [nsbs_pkg::LEFT_BITS-1:0] rsp_left_smaller,
   output logic signed [nsbs_pkg::LEFT_BITS-1:0] rsp_right_smaller,
   output logic                          rsp_status,
   output logic                          rsp_last_of_run,
   output nsbs_pkg::nsbs_stat_type       stat
);
   import nsbs_pkg::*;

   localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_BITS = VALUE_BITS + INDEX_BITS + LEFT_BITS;

   typedef enum logic [1:0] {
      ST_CMP = 2'b01,
      ST_TOP = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [LEFT_BITS-1:0]    depth_ff, depth_in;

   // cached top of stack
   logic signed [VALUE_BITS-1:0] top_key_ff, top_key_in;
   logic [INDEX_BITS-1:0]   top_idx_ff, top_idx_in;
   logic [LEFT_BITS-1:0]    top_left_ff, top_left_in;

   // answer waiting until its last-of-run mark is known
   logic                    pend_v_ff, pend_v_in;
   logic [INDEX_BITS-1:0]   pend_idx_ff, pend_idx_in;
   logic [LEFT_BITS-1:0]    pend_left_ff, pend_left_in;
   logic [LEFT_BITS-1:0]    pend_right_ff, pend_right_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]   rsp_idx_ff;
   logic [LEFT_BITS-1:0]    rsp_left_ff;
   logic [LEFT_BITS-1:0]    rsp_right_ff;
   logic                    rsp_status_ff;
   logic                    rsp_last_ff;

   // stack memory
   logic [ENTRY_BITS-1:0]   stack_mem_ff [DEPTH];
   logic [ENTRY_BITS-1:0]   rd_ff;
   logic [ENTRY_BITS-1:0]   wr_entry;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic                    rd_en;
   logic                    mem_we;

   logic                    is_push, is_flush, is_ovf;
   logic                    top_valid, pop_cond, out_free;
   logic [LEFT_BITS-1:0]    right_ans;
   logic [LEFT_BITS-1:0]    new_left;
   logic                    emit;
   logic [INDEX_BITS-1:0]   emit_idx;
   logic [LEFT_BITS-1:0]    emit_left;
   logic [LEFT_BITS-1:0]    emit_right;
   logic                    emit_status;
   logic                    emit_last;

   assign is_push   = (head_slot.tag.kind == KIND_PUSH);
   assign is_flush  = (head_slot.tag.kind == KIND_FLUSH);
   assign is_ovf    = (head_slot.tag.kind == KIND_OVERFLOW);
   assign top_valid = (depth_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_cond  = head_slot.valid && top_valid &&
                      (is_flush || (is_push && (top_key_ff > head_value)));
   assign right_ans = is_flush ? NONE_INDEX : {1'b0, head_slot.tag.index};
   assign new_left  = !top_valid ? NONE_INDEX :
                      (top_key_ff == head_value) ? top_left_ff : {1'b0, top_idx_ff};
   assign wr_entry  = {head_value, head_slot.tag.index, new_left};
   assign rd_addr   = ADDR_BITS'(depth_ff - LEFT_BITS'(2));
   assign wr_addr   = ADDR_BITS'(depth_ff);

   // sequence pops and pushes
   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      top_key_in    = top_key_ff;
      top_idx_in    = top_idx_ff;
      top_left_in   = top_left_ff;
      pend_v_in     = pend_v_ff;
      pend_idx_in   = pend_idx_ff;
      pend_left_in  = pend_left_ff;
      pend_right_in = pend_right_ff;
      head_pop      = 1'b0;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      emit          = 1'b0;
      emit_idx      = pend_idx_ff;
      emit_left     = pend_left_ff;
      emit_right    = pend_right_ff;
      emit_status   = STATUS_OK;
      emit_last     = 1'b0;
      unique case (state_ff)
         ST_CMP: begin
            if (head_slot.valid) begin
               if (is_ovf) begin
                  // answer a dropped push at once
                  if (out_free) begin
                     emit        = 1'b1;
                     emit_idx    = '0;
                     emit_left   = NONE_INDEX;
                     emit_right  = NONE_INDEX;
                     emit_status = STATUS_OVERFLOW;
                     emit_last   = 1'b1;
                     head_pop    = 1'b1;
                  end
               end else if (pop_cond) begin
                  // retire the top entry and fetch the one below
                  if (!pend_v_ff || out_free) begin
                     emit          = pend_v_ff;
                     pend_v_in     = 1'b1;
                     pend_idx_in   = top_idx_ff;
                     pend_left_in  = top_left_ff;
                     pend_right_in = right_ans;
                     depth_in      = depth_ff - 1'b1;
                     rd_en         = 1'b1;
                     state_in      = ST_TOP;
                  end
               end else if (!pend_v_ff || out_free) begin
                  // close the run and finish the word
                  emit      = pend_v_ff;
                  emit_last = 1'b1;
                  pend_v_in = 1'b0;
                  head_pop  = 1'b1;
                  if (is_push) begin
                     mem_we      = 1'b1;
                     top_key_in  = head_value;
                     top_idx_in  = head_slot.tag.index;
                     top_left_in = new_left;
                     depth_in    = depth_ff + 1'b1;
                  end
               end
            end
         end
         ST_TOP: begin
            // load the new top from memory
            top_key_in  = $signed(rd_ff[ENTRY_BITS-1 -: VALUE_BITS]);
            top_idx_in  = rd_ff[LEFT_BITS +: INDEX_BITS];
            top_left_in = rd_ff[LEFT_BITS-1:0];
            state_in    = ST_CMP;
         end
         default: begin
            state_in = ST_CMP;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CMP;
         depth_ff     <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_key_ff    <= top_key_in;
      top_idx_ff    <= top_idx_in;
      top_left_ff   <= top_left_in;
      pend_idx_ff   <= pend_idx_in;
      pend_left_ff  <= pend_left_in;
      pend_right_ff <= pend_right_in;
      if (emit) begin
         rsp_idx_ff    <= emit_idx;
         rsp_left_ff   <= emit_left;
         rsp_right_ff  <= emit_right;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   // stack memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_ff <= stack_mem_ff[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elem_index    = rsp_idx_ff;
   assign rsp_left_smaller  = $signed(rsp_left_ff);
   assign rsp_right_smaller = $signed(rsp_right_ff);
   assign rsp_status        = rsp_status_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign stat.depth        = depth_ff;
   assign stat.pending      = pend_v_ff;

endmodule

// ===== design/nearest_smaller_both_sides_unit.sv =====
// ----------------------------------------------------------------------------
// Nearest smaller both sides unit
// Push words (cmd 0) carry the elements of a sequence; for each element the
// unit returns the index of the nearest strictly smaller element to its left
// and to its right (-1 where there is none), equal values sharing answers.
// Answers come out when an element leaves the stack, top of stack first, and
// last_of_run marks the final answer caused by a word. A flush word (cmd 1)
// answers everything left with right index -1 and restarts numbering at 0.
// A push beyond DEPTH elements in one sequence is dropped and answered with
// status 1. A two-word queue sits behind req_ready. In the stack engine a
// push that pops nothing, a flush of an empty stack and an overflow finish
// in ST_CMP alone; each element popped passes through ST_CMP and then ST_TOP,
// where the registered read of the stack memory refills the cached top. The
// engine finishes one word before it takes the next from the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_smaller_both_sides_unit #(
   parameter int DEPTH      = nsbs_pkg::DEFAULT_DEPTH,
   parameter int VALUE_BITS = nsbs_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic signed [VALUE_BITS-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nsbs_pkg::INDEX_BITS-1:0]       rsp_elem_index,
   output logic signed [nsbs_pkg::LEFT_BITS-1:0] rsp_left_smaller,
   output logic signed [nsbs_pkg::LEFT_BITS-1:0] rsp_right_smaller,
   output logic                          rsp_status,
   output logic                          rsp_last_of_run
);
   import nsbs_pkg::*;

   nsbs_slot_type                wr_slot;
   nsbs_slot_type                head_slot;
   logic signed [VALUE_BITS-1:0] head_value;
   logic                         q_ready;
   logic                         head_pop;
   nsbs_stat_type                stat;

   nsbs_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .q_ready   (q_ready),
      .wr_slot   (wr_slot)
   );

   nsbs_queue #(
      .VALUE_BITS (VALUE_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_slot    (wr_slot),
      .wr_value   (req_value),
      .wr_ready   (q_ready),
      .head_slot  (head_slot),
      .head_value (head_value),
      .head_pop   (head_pop)
   );

   nsbs_back #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_slot         (head_slot),
      .head_value        (head_value),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_elem_index    (rsp_elem_index),
      .rsp_left_smaller  (rsp_left_smaller),
      .rsp_right_smaller (rsp_right_smaller),
      .rsp_status        (rsp_status),
      .rsp_last_of_run   (rsp_last_of_run),
      .stat              (stat)
   );

   // overflow answers stand alone and name no neighbours
   `NSBS_ASSERT(a_ovf_shape, clock, reset, (rsp_valid && rsp_status == STATUS_OVERFLOW) |-> (rsp_last_of_run && rsp_left_smaller == $signed(NONE_INDEX) && rsp_right_smaller == $signed(NONE_INDEX)), "overflow answer malformed")

   // a right neighbour always comes later in the sequence
   `NSBS_ASSERT(a_right_later, clock, reset, (rsp_valid && rsp_status == STATUS_OK) |-> (rsp_right_smaller == $signed(NONE_INDEX) || (rsp_right_smaller[6] == 1'b0 && rsp_right_smaller[5:0] > rsp_elem_index)), "right index not later")

   // a run left open still has its next answer waiting
   `NSBS_ASSERT(a_run_open, clock, reset, (rsp_valid && !rsp_last_of_run) |-> stat.pending, "run open with no answer waiting")

   // the stack never holds more than DEPTH elements
   `NSBS_ASSERT_NEVER(a_depth_bound, clock, reset, stat.depth > LEFT_BITS'(DEPTH), "stack depth beyond bound")

endmodule
